// ===== src/psf_normalize_radial_halo_core_assert.svh =====
// Assertion macros shared by the normalize and halo block.
// Expects aclk and aresetn to be visible where a macro is used.
`ifndef PSF_NORMALIZE_RADIAL_HALO_CORE_ASSERT_SVH
`define PSF_NORMALIZE_RADIAL_HALO_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PSFN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PSFN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/psfn_pkg.sv =====
// Shared types, constants and lookup tables of the normalize and halo block.
// No dependencies.
`default_nettype none
package psfn_pkg;

    localparam int TOT_W = 40;
    localparam int LEN_W = 6;
    localparam int SCALE_W = 32;
    localparam int OUT_W = 24;
    localparam logic [23:0] NORM_K = 24'd13505659;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;
    localparam logic [LEN_W-1:0] DIV_LAST = 6'd46;
    localparam logic [LEN_W-1:0] LEN_FULL = 6'd40;

    localparam logic REG_IMAGE_SIZE = 1'b0;
    localparam logic REG_SUBSAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_NORM = 3'b010,
        ST_DIV  = 3'b100
    } fstate_t;

    typedef enum logic [1:0] {
        BAND_FAR  = 2'd0,
        BAND_MID  = 2'd1,
        BAND_NEAR = 2'd2,
        BAND_FLAT = 2'd3
    } band_t;

    function automatic logic [16:0] lg_tab(input logic [4:0] idx);
        logic [16:0] r;
        unique case (idx)
            5'd0: r = 17'd0;
            5'd1: r = 17'd5732;
            5'd2: r = 17'd11136;
            5'd3: r = 17'd16248;
            5'd4: r = 17'd21098;
            5'd5: r = 17'd25711;
            5'd6: r = 17'd30109;
            5'd7: r = 17'd34312;
            5'd8: r = 17'd38336;
            5'd9: r = 17'd42196;
            5'd10: r = 17'd45904;
            5'd11: r = 17'd49472;
            5'd12: r = 17'd52911;
            5'd13: r = 17'd56229;
            5'd14: r = 17'd59434;
            5'd15: r = 17'd62534;
            5'd16: r = 17'd65536;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    function automatic logic [17:0] ex_tab(input logic [4:0] idx);
        logic [17:0] r;
        unique case (idx)
            5'd0: r = 18'd65536;
            5'd1: r = 18'd68438;
            5'd2: r = 18'd71468;
            5'd3: r = 18'd74632;
            5'd4: r = 18'd77936;
            5'd5: r = 18'd81386;
            5'd6: r = 18'd84990;
            5'd7: r = 18'd88752;
            5'd8: r = 18'd92682;
            5'd9: r = 18'd96785;
            5'd10: r = 18'd101070;
            5'd11: r = 18'd105545;
            5'd12: r = 18'd110218;
            5'd13: r = 18'd115098;
            5'd14: r = 18'd120194;
            5'd15: r = 18'd125515;
            5'd16: r = 18'd131072;
            default: r = 18'd65536;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== src/psfn_fifo.sv =====
// Small register queue between the front and back parts.
// No package dependencies.
`default_nettype none
module psfn_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] din,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      dout,
    output logic                  empty
);
    localparam int DEPTH = 4;
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0] cnt_reg;
    logic do_push, do_pop;

    assign full = cnt_reg == (AW+1)'(DEPTH);
    assign empty = cnt_reg == '0;
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign dout = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== src/psfn_front.sv =====
// Front part: accepts items, keeps the flux total and raster position, forms the scale.
// Depends on psfn_pkg and the assertion macro header.
`default_nettype none
`include "psf_normalize_radial_halo_core_assert.svh"
module psfn_front
    import psfn_pkg::*;
#(
    parameter int DW = 9,
    parameter int PXW = 24,
    parameter int IW = 8
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic           s_kind,
    input  wire logic [PXW-1:0] s_pixel,
    input  wire logic [DW-1:0]  dim,
    input  wire logic           q_full,
    output logic                q_push,
    output logic [IW-1:0]       q_data
);
    fstate_t state_reg, state_next;
    logic [TOT_W-1:0] total_reg, total_next;
    logic [TOT_W-1:0] den_reg, den_next;
    logic [TOT_W-1:0] rem_reg, rem_next;
    logic [SCALE_W-1:0] scale_reg, scale_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] div_cnt_reg, div_cnt_next;
    logic [DW-1:0] col_reg, col_next, row_reg, row_next;
    logic pass_done_reg, pass_done_next;

    logic base_clear, acc, adv_end, col_wrap, row_wrap;
    logic [DW-1:0] col_base, row_base, centre;
    logic [DW:0] col_inc, row_inc;
    logic [TOT_W-1:0] tot_base, tot_sat;
    logic [TOT_W:0] tot_sum, rem_shift;
    logic signed [DW:0] dx, dy;

    assign s_ready = (state_reg == ST_IDLE) && (!s_kind || (pass_done_reg && !q_full));
    assign acc = s_valid && s_ready;
    assign base_clear = !s_kind && pass_done_reg;
    assign col_base = base_clear ? '0 : col_reg;
    assign row_base = base_clear ? '0 : row_reg;
    assign tot_base = base_clear ? '0 : total_reg;
    assign tot_sum = {1'b0, tot_base} + (TOT_W+1)'(s_pixel);
    assign tot_sat = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
    assign col_inc = {1'b0, col_base} + 1'b1;
    assign row_inc = {1'b0, row_base} + 1'b1;
    assign col_wrap = col_inc >= {1'b0, dim};
    assign row_wrap = row_inc >= {1'b0, dim};
    assign adv_end = col_wrap && row_wrap;
    assign centre = dim >> 1;
    assign dx = $signed({1'b0, col_reg}) - $signed({1'b0, centre});
    assign dy = $signed({1'b0, row_reg}) - $signed({1'b0, centre});
    assign rem_shift = {rem_reg, 1'b0};

    assign q_push = acc && s_kind;
    assign q_data = {s_pixel, dx, dy, scale_reg, len_reg, adv_end};

    always_comb begin
        state_next = state_reg;
        total_next = total_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        scale_next = scale_reg;
        len_next = len_reg;
        div_cnt_next = div_cnt_reg;
        col_next = col_reg;
        row_next = row_reg;
        pass_done_next = pass_done_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    col_next = col_wrap ? '0 : col_inc[DW-1:0];
                    row_next = col_wrap ? (row_wrap ? '0 : row_inc[DW-1:0]) : row_base;
                    if (!s_kind) begin
                        total_next = tot_sat;
                        pass_done_next = 1'b0;
                        if (adv_end) begin
                            state_next = ST_NORM;
                            den_next = tot_sat;
                            len_next = LEN_FULL;
                        end
                    end else if (adv_end) begin
                        total_next = '0;
                        pass_done_next = 1'b0;
                    end
                end else if (s_valid && s_kind && !pass_done_reg) begin
                    state_next = ST_NORM;
                    den_next = total_reg;
                    len_next = LEN_FULL;
                end
            end
            ST_NORM: begin
                if (den_reg == '0) begin
                    scale_next = '0;
                    len_next = '0;
                    pass_done_next = 1'b1;
                    col_next = '0;
                    row_next = '0;
                    state_next = ST_IDLE;
                end else if (den_reg[TOT_W-1]) begin
                    rem_next = TOT_W'(NORM_K);
                    scale_next = '0;
                    div_cnt_next = '0;
                    state_next = ST_DIV;
                end else begin
                    den_next = den_reg << 1;
                    len_next = len_reg - 1'b1;
                end
            end
            ST_DIV: begin
                if (rem_shift >= {1'b0, den_reg}) begin
                    rem_next = TOT_W'(rem_shift - {1'b0, den_reg});
                    scale_next = {scale_reg[SCALE_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_shift[TOT_W-1:0];
                    scale_next = {scale_reg[SCALE_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_LAST) begin
                    pass_done_next = 1'b1;
                    col_next = '0;
                    row_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            scale_reg <= '0;
            len_reg <= '0;
            div_cnt_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
            pass_done_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            total_reg <= total_next;
            scale_reg <= scale_next;
            len_reg <= len_next;
            div_cnt_reg <= div_cnt_next;
            col_reg <= col_next;
            row_reg <= row_next;
            pass_done_reg <= pass_done_next;
        end
    end

    always_ff @(posedge aclk) begin
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    `PSFN_ASSERT_NOW(a_ready_only_idle, s_ready, state_reg == ST_IDLE, "ready outside idle")
    `PSFN_ASSERT_NOW(a_push_after_scale, q_push, pass_done_reg, "output item before scale")
    `PSFN_ASSERT_NOW(a_div_normalized, state_reg == ST_DIV, den_reg[TOT_W-1], "divisor not normalized")
    `PSFN_ASSERT_NEXT(a_div_finishes, (state_reg == ST_DIV) && (div_cnt_reg == DIV_LAST),
        pass_done_reg && (state_reg == ST_IDLE), "division did not finish")
endmodule
`default_nettype wire

// ===== src/psfn_log2.sv =====
// Pipelined log2 unit, three register stages, result in unsigned Q16.
// Depends on psfn_pkg for the log table.
`default_nettype none
module psfn_log2
    import psfn_pkg::*;
#(
    parameter int W = 32,
    parameter int OW = 22
) (
    input  wire logic         aclk,
    input  wire logic         en,
    input  wire logic [W-1:0] x,
    output logic [OW-1:0]     y
);
    localparam int NG = (W + 7) / 8;
    localparam int XW = NG * 8;
    localparam int NBW = $clog2(XW);

    logic [XW-1:0] xp, x1_reg, xn;
    logic [NG-1:0] gnz_c, gnz_reg;
    logic [2:0] gpos_c [NG];
    logic [2:0] gpos_reg [NG];
    logic [NBW-1:0] n_c, n2_reg;
    logic [15:0] f_c, f_reg;
    logic [3:0] idx;
    logic [11:0] frac;
    logic [16:0] lo, hi;
    logic [24:0] interp;

    assign xp = XW'(x);

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            gnz_c[g] = |xp[g*8 +: 8];
            gpos_c[g] = '0;
            for (int b = 0; b < 8; b++) begin
                if (xp[g*8 + b]) begin
                    gpos_c[g] = 3'(b);
                end
            end
        end
    end

    always_comb begin
        n_c = '0;
        for (int g = 0; g < NG; g++) begin
            if (gnz_reg[g]) begin
                n_c = NBW'(g * 8) + NBW'(gpos_reg[g]);
            end
        end
        xn = x1_reg << (NBW'(XW - 1) - n_c);
        f_c = xn[XW-2 -: 16];
    end

    assign idx = f_reg[15:12];
    assign frac = f_reg[11:0];
    assign lo = lg_tab({1'b0, idx});
    assign hi = lg_tab(5'({1'b0, idx}) + 5'd1);
    assign interp = 25'(hi - lo) * 25'(frac);

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg <= xp;
            gnz_reg <= gnz_c;
            gpos_reg <= gpos_c;
            n2_reg <= n_c;
            f_reg <= f_c;
            y <= OW'({n2_reg, 16'b0}) + OW'(lo) + OW'(interp[24:12]);
        end
    end
endmodule
`default_nettype wire

// ===== src/psfn_back.sv =====
// Back part: normalizes queued pixels and adds the radial halo term, nine stages.
// Depends on psfn_pkg and psfn_log2.
`default_nettype none
module psfn_back
    import psfn_pkg::*;
#(
    parameter int DW = 9,
    parameter int PXW = 24,
    parameter int IW = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [15:0]       subsample,
    input  wire logic              q_empty,
    input  wire logic [IW-1:0]     q_data,
    output logic                   q_pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [OUT_W-1:0]       m_corrected_pixel,
    output logic                   m_last_pixel
);
    localparam int D2W = 2 * DW;
    localparam int QW = D2W + 32;
    localparam int QXW = ((QW + 7) / 8) * 8;
    localparam int LQW = $clog2(QXW) + 17;
    localparam int LSW = $clog2(32) + 17;
    localparam int PW = PXW + SCALE_W;
    localparam logic [QW-1:0] TH_FAR = QW'((64'd68121 << 28) / 64'd100);
    localparam logic [QW-1:0] TH_MID = QW'((64'd3249 << 28) / 64'd100);
    localparam logic [QW-1:0] TH_NEAR = QW'((64'd484 << 28) / 64'd100);
    localparam logic signed [24:0] LOG_R_OFS = 25'sd1835008;
    localparam logic signed [31:0] LOG_A_OFS = 32'sd262144;
    localparam logic signed [31:0] EXP_TOP = 32'sd1572864;

    logic en;
    logic [PXW-1:0] in_pix;
    logic signed [DW:0] in_dx, in_dy;
    logic [SCALE_W-1:0] in_scale;
    logic [LEN_W-1:0] in_len;
    logic in_last;
    logic [31:0] s2_reg;
    logic [LSW-1:0] log_s2;
    logic [LQW-1:0] log_q;

    logic [9:1] vld_reg;
    logic [9:1] last_reg;
    logic [D2W-1:0] d2_1_reg;
    logic [PW-1:0] prod_1_reg;
    logic [LEN_W-1:0] len_1_reg;
    logic nz_1_reg;
    logic [QW-1:0] q_2_reg;
    logic [OUT_W-1:0] norm_reg [2:8];
    band_t band_reg [3:6];
    logic qz_reg [3:5];
    logic signed [42:0] pw_6_reg;
    logic signed [31:0] v_7_reg;
    logic [17:0] m_8_reg;
    logic [4:0] n_8_reg;
    logic neg_8_reg, sat_8_reg;
    logic [OUT_W-1:0] out_reg;

    logic signed [2*DW+1:0] sqx, sqy;
    logic [6:0] sh;
    logic [PW-1:0] shifted;
    logic [OUT_W-1:0] norm_c;
    band_t band_c;
    logic signed [24:0] lr2;
    logic signed [17:0] pcoef;
    logic signed [31:0] ccoef;
    logic signed [42:0] pw_adj;
    logic signed [26:0] pdiv;
    logic [3:0] eidx;
    logic [11:0] efrac;
    logic [17:0] elo, ehi;
    logic [24:0] einterp;
    logic [40:0] hx;
    logic [OUT_W-1:0] halo;
    logic [OUT_W:0] total_out;

    assign en = !vld_reg[9] || m_ready;
    assign q_pop = en && !q_empty;
    assign {in_pix, in_dx, in_dy, in_scale, in_len, in_last} = q_data;

    assign sqx = in_dx * in_dx;
    assign sqy = in_dy * in_dy;

    assign sh = 7'(len_1_reg) + 7'd7;
    assign shifted = prod_1_reg >> sh;
    assign norm_c = !nz_1_reg ? '0 : ((shifted > PW'(OUT_MAX)) ? OUT_MAX : shifted[OUT_W-1:0]);

    always_comb begin
        if (q_2_reg > TH_FAR) begin
            band_c = BAND_FAR;
        end else if (q_2_reg > TH_MID) begin
            band_c = BAND_MID;
        end else if (q_2_reg > TH_NEAR) begin
            band_c = BAND_NEAR;
        end else begin
            band_c = BAND_FLAT;
        end
    end

    assign lr2 = qz_reg[5] ? '0 : ($signed(25'(log_q)) - LOG_R_OFS);

    always_comb begin
        unique case (band_reg[5])
            BAND_FAR: pcoef = -18'sd98304;
            BAND_MID: pcoef = -18'sd36045;
            BAND_NEAR: pcoef = -18'sd91750;
            default: pcoef = '0;
        endcase
    end

    always_comb begin
        unique case (band_reg[6])
            BAND_FAR: ccoef = -32'sd93928;
            BAND_MID: ccoef = -32'sd680633;
            BAND_NEAR: ccoef = -32'sd401594;
            default: ccoef = -32'sd610327;
        endcase
    end

    assign pw_adj = pw_6_reg + (pw_6_reg[42] ? 43'sd65535 : 43'sd0);
    assign pdiv = 27'(pw_adj >>> 16);

    assign eidx = v_7_reg[15:12];
    assign efrac = v_7_reg[11:0];
    assign elo = ex_tab({1'b0, eidx});
    assign ehi = ex_tab(5'({1'b0, eidx}) + 5'd1);
    assign einterp = 25'(ehi - elo) * 25'(efrac);

    assign hx = 41'(m_8_reg) << n_8_reg;
    always_comb begin
        if (s2_reg == '0 || neg_8_reg) begin
            halo = '0;
        end else if (sat_8_reg) begin
            halo = OUT_MAX;
        end else begin
            halo = hx[39:16];
        end
    end
    assign total_out = {1'b0, norm_reg[8]} + {1'b0, halo};

    psfn_log2 #(.W(32), .OW(LSW)) u_log_s2 (
        .aclk (aclk),
        .en   (1'b1),
        .x    (s2_reg),
        .y    (log_s2)
    );

    psfn_log2 #(.W(QW), .OW(LQW)) u_log_q (
        .aclk (aclk),
        .en   (en),
        .x    (q_2_reg),
        .y    (log_q)
    );

    always_ff @(posedge aclk) begin
        s2_reg <= 32'(subsample) * 32'(subsample);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[8:1], q_pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            last_reg <= {last_reg[8:1], in_last};
            d2_1_reg <= D2W'(sqx + sqy);
            prod_1_reg <= PW'(in_pix) * PW'(in_scale);
            len_1_reg <= in_len;
            nz_1_reg <= in_scale != '0;
            q_2_reg <= QW'(d2_1_reg) * QW'(s2_reg);
            norm_reg[2] <= norm_c;
            for (int k = 3; k <= 8; k++) begin
                norm_reg[k] <= norm_reg[k-1];
            end
            band_reg[3] <= band_c;
            band_reg[4] <= band_reg[3];
            band_reg[5] <= band_reg[4];
            band_reg[6] <= band_reg[5];
            qz_reg[3] <= q_2_reg == '0;
            qz_reg[4] <= qz_reg[3];
            qz_reg[5] <= qz_reg[4];
            pw_6_reg <= 43'(lr2) * 43'(pcoef);
            v_7_reg <= $signed(32'(log_s2)) - LOG_A_OFS + ccoef
                + ((band_reg[6] == BAND_FLAT) ? 32'sd0 : 32'(pdiv));
            neg_8_reg <= v_7_reg < 0;
            sat_8_reg <= v_7_reg >= EXP_TOP;
            n_8_reg <= v_7_reg[20:16];
            m_8_reg <= elo + 18'(einterp[24:12]);
            out_reg <= total_out[OUT_W] ? OUT_MAX : total_out[OUT_W-1:0];
        end
    end

    assign m_valid = vld_reg[9];
    assign m_corrected_pixel = out_reg;
    assign m_last_pixel = last_reg[9];
endmodule
`default_nettype wire

// ===== src/psf_normalize_radial_halo_core.sv =====
// Top level of the flux normalize and radial halo block: configuration registers and wiring.
// Depends on psfn_pkg, psfn_front, psfn_fifo and psfn_back.
//
// Usage: an image is streamed twice in raster order on the s_ channel. Items of kind 0
// (sum pass) are summed and produce no transaction on the m_ channel. Items of kind 1
// (output pass) each produce one m_ transaction carrying the normalized pixel plus the
// halo term, with m_last_pixel set on the final pixel of the pass.
// The cfg_ channel writes image_size (index 0) and subsample_ratio (index 1); it is
// always ready and must only be used while no item is in flight.
// Throughput is one item per cycle while the queue has room, except that forming the
// scale after the sum pass (or at an early output pixel) holds s_ready low while the
// divisor is normalized and the restoring divider runs; the divider is skipped for a
// zero total. An accepted output item reaches m_valid through the four-entry queue and
// the nine-stage back pipeline. When m_valid is high and m_ready is low the back
// pipeline holds; the front keeps accepting until the queue fills. Synchronous reset
// clears totals, scale, counters and all valid bits and loads image_size 256 and
// subsample_ratio 16384.
`default_nettype none
module psf_normalize_radial_halo_core
    import psfn_pkg::*;
#(
    parameter int MAX_DIM = 256,
    parameter int PIXEL_BITS = 24
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_kind,
    input  wire logic [23:0] s_pixel_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [23:0]      m_corrected_pixel,
    output logic             m_last_pixel,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int PXW = (PIXEL_BITS < 24) ? PIXEL_BITS : 24;
    localparam int IW = PXW + 2 * (DW + 1) + SCALE_W + LEN_W + 1;

    logic [8:0] image_size_reg;
    logic [15:0] subsample_reg;
    logic [31:0] dim_wide;
    logic [DW-1:0] dim;
    logic q_full, q_push, q_pop, q_empty;
    logic [IW-1:0] q_din, q_dout;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_size_reg <= 9'd256;
            subsample_reg <= 16'd16384;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_IMAGE_SIZE) begin
                image_size_reg <= cfg_data[8:0];
            end else if (cfg_index == REG_SUBSAMPLE) begin
                subsample_reg <= cfg_data;
            end
        end
    end

    always_comb begin
        if (image_size_reg == '0) begin
            dim_wide = 32'd1;
        end else if (32'(image_size_reg) > 32'(MAX_DIM)) begin
            dim_wide = 32'(MAX_DIM);
        end else begin
            dim_wide = 32'(image_size_reg);
        end
    end
    assign dim = DW'(dim_wide);

    psfn_front #(.DW(DW), .PXW(PXW), .IW(IW)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .s_pixel (s_pixel_value[PXW-1:0]),
        .dim     (dim),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_data  (q_din)
    );

    psfn_fifo #(.WIDTH(IW)) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .full    (q_full),
        .pop     (q_pop),
        .dout    (q_dout),
        .empty   (q_empty)
    );

    psfn_back #(.DW(DW), .PXW(PXW), .IW(IW)) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .subsample         (subsample_reg),
        .q_empty           (q_empty),
        .q_data            (q_dout),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_corrected_pixel (m_corrected_pixel),
        .m_last_pixel      (m_last_pixel)
    );
endmodule
`default_nettype wire

// ===== bench/psf_normalize_radial_halo_core_test.sv =====
// Self-checking bench for psf_normalize_radial_halo_core: flux sum, scale and halo output.
// Depends on psfn_pkg and the block's RTL; a local predictor computes expected pixels.
`default_nettype none
module psf_normalize_radial_halo_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import psfn_pkg::*;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_kind = 1'b0;
    logic [23:0] s_pixel_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [23:0] m_corrected_pixel;
    logic m_last_pixel;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = REG_IMAGE_SIZE;
    logic [15:0] cfg_data = '0;

    always #2 aclk = ~aclk;

    psf_normalize_radial_halo_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind), .s_pixel_value(s_pixel_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_corrected_pixel(m_corrected_pixel),
        .m_last_pixel(m_last_pixel),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    typedef struct packed {
        logic [23:0] pix;
        logic        last;
    } corrected_t;

    localparam bit KIND_SUM = 1'b0;
    localparam bit KIND_OUT = 1'b1;

    int unsigned lg_q[17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
        42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};
    int unsigned ex_q[17] = '{65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752,
        92682, 96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072};

    logic [8:0] pm_size;
    logic [15:0] pm_sub;
    logic [39:0] pm_total;
    logic [31:0] pm_scale;
    int unsigned pm_col, pm_row;
    bit pm_done;

    corrected_t pending[$];
    int errors = 0;
    int n_results = 0;
    int n_items = 0;
    int send_idle = 0;
    int recv_idle = 0;

    function automatic int unsigned blen(logic [63:0] x);
        int unsigned n;
        n = 0;
        while (n < 64 && (x >> n) != 0) n++;
        return n;
    endfunction

    function automatic longint lg2_q16(logic [63:0] x);
        int unsigned n, f, i, w, v;
        logic [63:0] t;
        n = blen(x) - 1;
        t = (x << (63 - n)) >> 47;
        f = t[15:0];
        i = f >> 12;
        w = f & 12'hFFF;
        v = lg_q[i] + (((lg_q[i+1] - lg_q[i]) * w) >> 12);
        return longint'(n) * 65536 + longint'(v);
    endfunction

    function automatic logic [23:0] pow2_sat(longint v);
        int unsigned n, f, i, w, m;
        logic [63:0] t;
        if (v < 0) return 24'd0;
        if (v >= 24 * 65536) return OUT_MAX;
        n = v >> 16;
        f = v & 16'hFFFF;
        i = f >> 12;
        w = f & 12'hFFF;
        m = ex_q[i] + (((ex_q[i+1] - ex_q[i]) * w) >> 12);
        t = (64'(m) << n) >> 16;
        return t[23:0];
    endfunction

    function automatic logic [23:0] halo_term(longint dx, longint dy);
        logic [63:0] s2, q, q100;
        longint v, lr2;
        s2 = 64'(pm_sub) * 64'(pm_sub);
        if (s2 == 0) return 24'd0;
        q = 64'(dx * dx + dy * dy) * s2;
        q100 = q * 100;
        v = lg2_q16(s2) - 4 * 65536;
        lr2 = 0;
        if (q != 0) lr2 = lg2_q16(q) - 28 * 65536;
        if (q100 > (64'd68121 << 28)) v += -93928 + (lr2 * -98304) / 65536;
        else if (q100 > (64'd3249 << 28)) v += -680633 + (lr2 * -36045) / 65536;
        else if (q100 > (64'd484 << 28)) v += -401594 + (lr2 * -91750) / 65536;
        else v += -610327;
        return pow2_sat(v);
    endfunction

    function automatic void form_norm_scale();
        logic [63:0] den, rem, quo;
        int unsigned len;
        if (pm_total == 0) begin
            pm_scale = 0;
            return;
        end
        len = blen(64'(pm_total));
        den = 64'(pm_total) << (40 - len);
        rem = 64'(NORM_K);
        quo = 0;
        for (int k = 0; k < 47; k++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo[0] = 1'b1;
            end
        end
        pm_scale = quo[31:0];
    endfunction

    function automatic int unsigned eff_dim();
        if (pm_size < 1) return 1;
        if (pm_size > 256) return 256;
        return pm_size;
    endfunction

    function automatic bit step_raster(int unsigned dim);
        if (pm_col + 1 >= dim) begin
            pm_col = 0;
            if (pm_row + 1 >= dim) begin
                pm_row = 0;
                return 1'b1;
            end
            pm_row++;
            return 1'b0;
        end
        pm_col++;
        return 1'b0;
    endfunction

    function automatic void predict_pixel(bit kind, logic [23:0] pix);
        int unsigned dim, len;
        logic [63:0] norm, sum;
        logic [40:0] acc;
        longint centre;
        bit last;
        corrected_t r;
        dim = eff_dim();
        if (kind == KIND_SUM) begin
            if (pm_done) begin
                pm_total = 0;
                pm_col = 0;
                pm_row = 0;
                pm_done = 0;
            end
            acc = 41'(pm_total) + 41'(pix);
            pm_total = acc[40] ? '1 : acc[39:0];
            if (step_raster(dim)) begin
                form_norm_scale();
                pm_done = 1;
            end
            return;
        end
        if (!pm_done) begin
            form_norm_scale();
            pm_col = 0;
            pm_row = 0;
            pm_done = 1;
        end
        norm = 0;
        if (pm_total != 0 && pm_scale != 0) begin
            len = blen(64'(pm_total));
            norm = (64'(pix) * 64'(pm_scale)) >> (len + 7);
            if (norm > 64'(OUT_MAX)) norm = 64'(OUT_MAX);
        end
        centre = dim / 2;
        sum = norm + 64'(halo_term(longint'(pm_col) - centre, longint'(pm_row) - centre));
        if (sum > 64'(OUT_MAX)) sum = 64'(OUT_MAX);
        last = step_raster(dim);
        if (last) begin
            pm_total = 0;
            pm_done = 0;
        end
        r.pix = sum[23:0];
        r.last = last;
        pending.push_back(r);
    endfunction

    task automatic send_pixel(bit kind, logic [23:0] pix);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_pixel_value <= pix;
        do @(posedge aclk); while (!s_ready);
        predict_pixel(kind, pix);
        n_items++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending.size() != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_IMAGE_SIZE) pm_size = value[8:0];
        else pm_sub = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [23:0] rand_pix();
        case ($urandom_range(3))
            0: return 24'd0;
            1: return OUT_MAX;
            2: return 24'($urandom_range(255));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_image(int unsigned dim, bit fixed, logic [23:0] v);
        for (int i = 0; i < dim * dim; i++) send_pixel(KIND_SUM, fixed ? v : rand_pix());
        for (int i = 0; i < dim * dim; i++) send_pixel(KIND_OUT, fixed ? v : rand_pix());
    endtask

    always @(posedge aclk) begin
        corrected_t e;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (pending.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
            end else begin
                e = pending.pop_front();
                if (m_corrected_pixel !== e.pix) begin
                    $error("corrected_pixel expected %0h actual %0h", e.pix, m_corrected_pixel);
                    errors++;
                end
                if (m_last_pixel !== e.last) begin
                    $error("last_pixel expected %0b actual %0b", e.last, m_last_pixel);
                    errors++;
                end
            end
        end
    end

    always @(negedge aclk) m_ready <= ($urandom_range(99) >= recv_idle);

    task automatic test_directed();
        write_reg(REG_IMAGE_SIZE, 16'd3);
        write_reg(REG_SUBSAMPLE, 16'd16384);
        send_image(3, 1'b1, OUT_MAX);
        send_image(3, 1'b1, 24'd0);
        write_reg(REG_SUBSAMPLE, 16'd0);
        send_image(2, 1'b1, 24'd1);
        write_reg(REG_SUBSAMPLE, 16'hFFFF);
        write_reg(REG_IMAGE_SIZE, 16'd0);
        send_pixel(KIND_SUM, 24'd5);
        send_pixel(KIND_OUT, 24'd7);
    endtask

    task automatic test_early_and_abandoned();
        write_reg(REG_IMAGE_SIZE, 16'd4);
        write_reg(REG_SUBSAMPLE, 16'd1);
        send_pixel(KIND_SUM, 24'hABCDEF);
        send_pixel(KIND_OUT, 24'h123456);
        send_pixel(KIND_OUT, 24'h000001);
        send_pixel(KIND_SUM, 24'h555555);
        for (int i = 0; i < 16; i++) send_pixel(KIND_OUT, rand_pix());
    endtask

    task automatic test_random_images(int unsigned budget);
        int unsigned sent, dim;
        sent = 0;
        while (sent < budget) begin
            dim = ($urandom_range(9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 6);
            write_reg(REG_IMAGE_SIZE, 16'(dim));
            case ($urandom_range(3))
                0: write_reg(REG_SUBSAMPLE, 16'($urandom_range(1, 65535)));
                1: write_reg(REG_SUBSAMPLE, 16'($urandom_range(8192, 40000)));
                2: write_reg(REG_SUBSAMPLE, 16'h8000 >> $urandom_range(15));
                default: write_reg(REG_SUBSAMPLE, 16'hFFFF);
            endcase
            if ($urandom_range(7) == 0) begin
                for (int i = 0; i < 2 * dim * dim; i++) begin
                    send_pixel(1'($urandom_range(1)), rand_pix());
                end
            end else begin
                send_image(dim, 1'b0, 24'd0);
            end
            sent += 2 * dim * dim;
        end
    endtask

    task automatic test_large_size();
        write_reg(REG_IMAGE_SIZE, 16'd256);
        write_reg(REG_SUBSAMPLE, 16'd16384);
        for (int i = 0; i < 40; i++) send_pixel(KIND_SUM, rand_pix());
        for (int i = 0; i < 40; i++) send_pixel(KIND_OUT, rand_pix());
        write_reg(REG_IMAGE_SIZE, 16'h1FF);
        for (int i = 0; i < 20; i++) send_pixel(KIND_OUT, rand_pix());
    endtask

    initial begin
        pm_size = 9'd256;
        pm_sub = 16'd16384;
        pm_total = 0;
        pm_scale = 0;
        pm_col = 0;
        pm_row = 0;
        pm_done = 0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_early_and_abandoned();
        send_idle = 15;
        recv_idle = 71;
        test_random_images(160);
        drain();
        send_idle = 71;
        recv_idle = 15;
        test_random_images(160);
        send_idle = 0;
        recv_idle = 0;
        test_random_images(160);
        test_large_size();
        drain();
        $display("Sent %0d pixels over many image sizes and subsample ratios; checked %0d",
            n_items, n_results);
        $display("corrected pixels including early, abandoned and zero-flux passes.");
        if (errors == 0 && pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
